// ----- rtl/kcl_pkg.sv -----
package kcl_pkg;

    localparam int FIFO_DEPTH  = 16;
    localparam int CODE_LENGTH = 4;

    localparam int PTR_W  = $clog2(FIFO_DEPTH);
    localparam int WIN_W  = CODE_LENGTH * 8;
    localparam int CNT_W  = $clog2(CODE_LENGTH + 1);
    localparam int CODE_W = 32;

    localparam logic [CODE_W-1:0] CODE_RESET = 32'h4142_4344;

    typedef logic [7:0] t_char;
    typedef logic [2:0] t_status;

    localparam t_status ST_STORED  = 3'd0;
    localparam t_status ST_FULL    = 3'd1;
    localparam t_status ST_NO_COL  = 3'd2;
    localparam t_status ST_EMPTY   = 3'd3;
    localparam t_status ST_TAKEN   = 3'd4;
    localparam t_status ST_WRONG   = 3'd5;
    localparam t_status ST_CORRECT = 3'd6;

    // keypad legend, index {row, col}
    localparam t_char KEYMAP [16] = '{
        8'h31, 8'h32, 8'h33, 8'h41,
        8'h34, 8'h35, 8'h36, 8'h42,
        8'h37, 8'h38, 8'h39, 8'h43,
        8'h2A, 8'h30, 8'h23, 8'h44
    };

    // packed so that status lands in the lowest bits
    typedef struct packed {
        logic [3:0] fifo_level;
        logic [2:0] chars_entered;
        logic       lock_bit;
        t_char      key_char;
        t_status    status;
    } t_result;

    typedef struct packed {
        logic             we;
        logic [PTR_W-1:0] waddr;
        t_char            wdata;
        logic             re;
        logic [PTR_W-1:0] raddr;
    } t_ram_req;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(FIFO_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [PTR_W-1:0] fifo_fill(input logic [PTR_W-1:0] w,
                                                  input logic [PTR_W-1:0] r);
        logic [PTR_W:0] sum;
        if (w >= r) begin
            sum = {1'b0, w} - {1'b0, r};
        end else begin
            sum = {1'b0, w} + (PTR_W+1)'(FIFO_DEPTH) - {1'b0, r};
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

// ----- rtl/kcl_ram.sv -----
module kcl_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/kcl_ctrl.sv -----
module kcl_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [kcl_pkg::CODE_W-1:0]      i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_func,
    input  logic [1:0]                      i_row,
    input  logic [1:0]                      i_col,
    input  logic                            i_col_found,
    output kcl_pkg::t_ram_req               o_ram_req,
    input  kcl_pkg::t_char                  i_ram_rdata,
    output logic                            o_res_valid,
    output kcl_pkg::t_result                o_res,
    input  logic                            i_res_pop
);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state                          r_state, n_state;
    logic [kcl_pkg::PTR_W-1:0]       r_rptr, n_rptr;
    logic [kcl_pkg::PTR_W-1:0]       r_wptr, n_wptr;
    logic [kcl_pkg::WIN_W-1:0]       r_win, n_win;
    logic [kcl_pkg::CNT_W-1:0]       r_cnt, n_cnt;
    logic                            r_lock, n_lock;
    logic [kcl_pkg::CODE_W-1:0]      r_code;
    logic                            r_res_vld, n_res_vld;
    kcl_pkg::t_result                r_res, n_res;

    logic                            accept;
    logic [kcl_pkg::PTR_W-1:0]       level;
    logic [kcl_pkg::CNT_W:0]         cnt_inc;
    logic [63:0]                     code_ext;

    assign o_in_ready = (r_state == S_IDLE) && !r_res_vld;
    assign accept     = i_in_valid && o_in_ready;
    assign level      = kcl_pkg::fifo_fill(r_wptr, r_rptr);
    assign cnt_inc    = {1'b0, r_cnt} + 1'b1;
    assign code_ext   = 64'(r_code);

    always_comb begin
        n_state    = r_state;
        n_rptr     = r_rptr;
        n_wptr     = r_wptr;
        n_win      = r_win;
        n_cnt      = r_cnt;
        n_lock     = r_lock;
        n_res_vld  = r_res_vld && !i_res_pop;
        n_res      = r_res;
        o_ram_req  = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res.key_char = '0;
                    if (!i_func) begin
                        n_res_vld = 1'b1;
                        if (!i_col_found) begin
                            n_res.status = kcl_pkg::ST_NO_COL;
                        end else if (level == kcl_pkg::PTR_W'(kcl_pkg::FIFO_DEPTH - 1)) begin
                            n_res.status = kcl_pkg::ST_FULL;
                        end else begin
                            o_ram_req.we    = 1'b1;
                            o_ram_req.waddr = r_wptr;
                            o_ram_req.wdata = kcl_pkg::KEYMAP[{i_row, i_col}];
                            n_wptr          = kcl_pkg::ptr_inc(r_wptr);
                            n_res.status    = kcl_pkg::ST_STORED;
                            n_res.key_char  = kcl_pkg::KEYMAP[{i_row, i_col}];
                        end
                    end else if (level == '0) begin
                        n_res_vld    = 1'b1;
                        n_res.status = kcl_pkg::ST_EMPTY;
                    end else begin
                        // fetch the oldest character; finish next cycle
                        o_ram_req.re    = 1'b1;
                        o_ram_req.raddr = r_rptr;
                        n_rptr          = kcl_pkg::ptr_inc(r_rptr);
                        n_state         = S_READ;
                    end
                    n_res.lock_bit      = r_lock;
                    n_res.chars_entered = 3'(r_cnt);
                    n_res.fifo_level    = 4'(kcl_pkg::fifo_fill(n_wptr, n_rptr));
                end
            end
            S_READ: begin
                n_win          = kcl_pkg::WIN_W'({r_win, i_ram_rdata});
                n_res.key_char = i_ram_rdata;
                n_res.status   = kcl_pkg::ST_TAKEN;
                n_cnt          = cnt_inc[kcl_pkg::CNT_W-1:0];
                if (cnt_inc == (kcl_pkg::CNT_W+1)'(kcl_pkg::CODE_LENGTH)) begin
                    n_cnt = '0;
                    if (n_win == code_ext[kcl_pkg::WIN_W-1:0]) begin
                        n_lock       = 1'b0;
                        n_res.status = kcl_pkg::ST_CORRECT;
                    end else begin
                        n_lock       = 1'b1;
                        n_res.status = kcl_pkg::ST_WRONG;
                    end
                end
                n_res.lock_bit      = n_lock;
                n_res.chars_entered = 3'(n_cnt);
                n_res.fifo_level    = 4'(level);
                n_res_vld           = 1'b1;
                n_state             = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rptr    <= '0;
            r_wptr    <= '0;
            r_win     <= '0;
            r_cnt     <= '0;
            r_lock    <= 1'b1;
            r_code    <= kcl_pkg::CODE_RESET;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rptr    <= n_rptr;
            r_wptr    <= n_wptr;
            r_win     <= n_win;
            r_cnt     <= n_cnt;
            r_lock    <= n_lock;
            r_res_vld <= n_res_vld;
            if (i_cfg_we) begin
                r_code <= i_cfg_wdata;
            end
        end
        r_res <= n_res;
    end

    assign o_res_valid = r_res_vld;
    assign o_res       = r_res;

endmodule

// ----- rtl/keypad_combination_lock_top.sv -----
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: row, col, col_found; tuser: func
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: status, key_char, lock_bit,
//                                                      chars_entered, fifo_level
// cfg       in   i_cfg_we                       i_cfg_wdata: code_word
//
// A key press is decided in the controller's idle state; a check step also passes through a
// read state for the registered read of the key FIFO memory. Each result goes to the result
// register, then to the output register that offers it; input is not ready while one waits.
// Reset is synchronous, active low; the FIFO memory needs no clearing pass.
// The output register holds a finished beat while the next input beat is taken;
// a second finished beat waits in the controller and input stalls until it moves.
module keypad_combination_lock_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [1:0] row, [3:2] col, [4] col_found, [7:5] zero
    input  logic        s_axis_tuser,   // [0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [2:0] status, [10:3] key_char, [11] lock_bit,
                                        // [14:12] chars_entered, [18:15] fifo_level
);

    kcl_pkg::t_ram_req ram_req;
    kcl_pkg::t_char    ram_rdata;
    kcl_pkg::t_result  res;
    logic              res_valid;
    logic              res_pop;
    kcl_pkg::t_result  r_out;
    logic              r_out_vld;

    kcl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_func      (s_axis_tuser),
        .i_row       (s_axis_tdata[1:0]),
        .i_col       (s_axis_tdata[3:2]),
        .i_col_found (s_axis_tdata[4]),
        .o_ram_req   (ram_req),
        .i_ram_rdata (ram_rdata),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_pop   (res_pop)
    );

    kcl_ram #(
        .DEPTH  (kcl_pkg::FIFO_DEPTH),
        .WIDTH  (8),
        .ADDR_W (kcl_pkg::PTR_W)
    ) u_fifo_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    // load the output register when it is empty or being drained
    assign res_pop = res_valid && (!r_out_vld || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_pop) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
        if (res_pop) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {5'b0, r_out};

endmodule
